FILE: sv/dalc_pkg.sv
// Shared types, constants and helper functions for the door ambient light controller.
// Used by every module of the block; depends on nothing else.
package dalc_pkg;

    localparam int NOW_W      = 32;
    localparam int GEAR_W     = 3;
    localparam int DOORS      = 4;
    localparam int SIDE_DOORS = 2;
    localparam int BRIGHT_W   = 8;
    localparam int SETTLE_W   = 16;
    localparam int TIME_CFG_W = 20;
    localparam int CODE_W     = 3;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Reset values of the configuration registers.
    localparam logic [GEAR_W-1:0]     PARK_RST   = 3'd1;
    localparam logic [SETTLE_W-1:0]   SETTLE_RST = 16'd1000;
    localparam logic [BRIGHT_W-1:0]   MINB_RST   = 8'hC8;
    localparam logic [TIME_CFG_W-1:0] QUIET_RST  = 20'd15000;
    localparam logic [TIME_CFG_W-1:0] SLOW_RST   = 20'd10000;
    localparam logic [TIME_CFG_W-1:0] FAST_RST   = 20'd30;

    // Register indexes; the byte address is four times the index.
    typedef enum logic [2:0] {
        REG_PARK   = 3'd0,
        REG_SETTLE = 3'd1,
        REG_MINB   = 3'd2,
        REG_QUIET  = 3'd3,
        REG_SLOW   = 3'd4,
        REG_FAST   = 3'd5
    } reg_idx_t;

    // Door mode codes as they appear on the result.
    localparam logic [CODE_W-1:0] MODE_SETTLING   = 3'd0;
    localparam logic [CODE_W-1:0] MODE_IDLE       = 3'd1;
    localparam logic [CODE_W-1:0] MODE_OPENED     = 3'd2;
    localparam logic [CODE_W-1:0] MODE_DOOR_WAIT  = 3'd3;
    localparam logic [CODE_W-1:0] MODE_WAIT       = 3'd4;
    localparam logic [CODE_W-1:0] MODE_BLIND      = 3'd5;
    localparam logic [CODE_W-1:0] MODE_TURN       = 3'd6;
    localparam logic [CODE_W-1:0] MODE_TURN_BLIND = 3'd7;

    // Door light state, held one-hot.
    typedef enum logic [7:0] {
        ST_SETTLING   = 8'b0000_0001,
        ST_IDLE       = 8'b0000_0010,
        ST_OPENED     = 8'b0000_0100,
        ST_DOOR_WAIT  = 8'b0000_1000,
        ST_WAIT       = 8'b0001_0000,
        ST_BLIND      = 8'b0010_0000,
        ST_TURN       = 8'b0100_0000,
        ST_TURN_BLIND = 8'b1000_0000
    } door_state_t;

    typedef struct packed {
        logic [GEAR_W-1:0]     park_gear_code;
        logic [SETTLE_W-1:0]   settle_time_ms;
        logic [BRIGHT_W-1:0]   min_brightness;
        logic [TIME_CFG_W-1:0] quiet_age_ms;
        logic [TIME_CFG_W-1:0] slow_interval_ms;
        logic [TIME_CFG_W-1:0] fast_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic [NOW_W-1:0]    now_ms;
        logic [GEAR_W-1:0]   gear;
        logic [DOORS-1:0]    doors_ajar;
        logic                display_on;
        logic                blind_right;
        logic                blind_left;
        logic                turn_right;
        logic                turn_left;
        logic [BRIGHT_W-1:0] brightness_in;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0]   door0_mode;
        logic [CODE_W-1:0]   door1_mode;
        logic [CODE_W-1:0]   door2_mode;
        logic [CODE_W-1:0]   door3_mode;
        logic [BRIGHT_W-1:0] light_level;
        logic                footwell_lit;
        logic [NOW_W-1:0]    youngest_age_ms;
        logic                send_now;
    } out_item_t;

    // Outcome of one door's rule pass.
    typedef struct packed {
        door_state_t      state;
        logic             restamp;
        logic             changed;
        logic [NOW_W-1:0] age;
    } door_upd_t;

    // Status of the send bookkeeping, seen by the top level.
    typedef struct packed {
        logic             change_pending;
        logic [NOW_W-1:0] last_send_ms;
    } send_stat_t;

    function automatic logic [CODE_W-1:0] mode_code(door_state_t s);
        logic [CODE_W-1:0] c;
        unique case (s)
            ST_SETTLING:   c = MODE_SETTLING;
            ST_IDLE:       c = MODE_IDLE;
            ST_OPENED:     c = MODE_OPENED;
            ST_DOOR_WAIT:  c = MODE_DOOR_WAIT;
            ST_WAIT:       c = MODE_WAIT;
            ST_BLIND:      c = MODE_BLIND;
            ST_TURN:       c = MODE_TURN;
            ST_TURN_BLIND: c = MODE_TURN_BLIND;
            default:       c = MODE_SETTLING;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/door_ambient_light_controller.sv
// Top level of the door ambient light controller: handshakes, input and result registers.
// Depends on dalc_pkg, dalc_cfg_regs and dalc_core.
//
//  Channel   Handshake           Payload                      Direction
//  in        in_valid/in_stall   in_data (in_item_t)          sample into the block
//  out       out_valid/out_stall out_data (out_item_t)        result out of the block
//  config    APB psel/penable    paddr/pwdata/prdata, pready  register access
//
// One transaction per cycle unless out_stall holds it: a sample is registered at its accepting
// edge, the door, brightness and send update runs in one pass from that register, and the
// result register loads from that pass when it is free, and out_valid is driven by it.
// Reset brings all doors to settling with zero stamps, a pending change and register defaults.
// A stalled result holds in the result register while the input register takes one more
// transaction; in_stall rises only when both registers are full and out_stall is high.
module door_ambient_light_controller
    import dalc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg;
    send_stat_t stat;
    out_item_t  result;

    logic       stage_valid_reg;
    logic       stage_valid_next;
    in_item_t   stage_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_reg;

    logic       in_fire;
    logic       advance;

    dalc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dalc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (stage_reg),
        .fire   (advance),
        .result (result),
        .stat   (stat)
    );

    // The sample in the input register is processed when the result register is free
    // or is handing over its transaction in this same cycle.
    assign advance  = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = stage_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;

    assign stage_valid_next = in_fire || (stage_valid_reg && !advance);
    assign out_valid_next   = advance || (out_valid_reg && out_stall);

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers load only on a transfer, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

`ifndef SYNTHESIS
    // The input side only stalls while a sample is waiting in the input register.
    a_stall_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> stage_valid_reg)
        else $error("input stalled with an empty input register");

    // A processed sample always shows up as a result on the next edge.
    a_advance_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("processed sample did not reach the result register");

    // A send clears the pending change and records the sample time.
    a_send_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.send_now)
        |=> (!stat.change_pending && stat.last_send_ms == $past(stage_reg.now_ms)))
        else $error("send did not clear the pending change or the send time");

    // With any door open the light level never drops below the floor.
    a_floor_applied: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_reg.doors_ajar != '0)
        |=> (out_data.light_level >= cfg.min_brightness))
        else $error("brightness floor not applied with a door open");
`endif

endmodule

FILE: sv/dalc_cfg_regs.sv
// Configuration register file behind the APB-style port.
// Depends on dalc_pkg for the register indexes, widths and reset values.
module dalc_cfg_regs
    import dalc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PARK:   cfg_next.park_gear_code   = pwdata[GEAR_W-1:0];
                REG_SETTLE: cfg_next.settle_time_ms   = pwdata[SETTLE_W-1:0];
                REG_MINB:   cfg_next.min_brightness   = pwdata[BRIGHT_W-1:0];
                REG_QUIET:  cfg_next.quiet_age_ms     = pwdata[TIME_CFG_W-1:0];
                REG_SLOW:   cfg_next.slow_interval_ms = pwdata[TIME_CFG_W-1:0];
                REG_FAST:   cfg_next.fast_interval_ms = pwdata[TIME_CFG_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PARK:   prdata = APB_DATA_W'(cfg_reg.park_gear_code);
            REG_SETTLE: prdata = APB_DATA_W'(cfg_reg.settle_time_ms);
            REG_MINB:   prdata = APB_DATA_W'(cfg_reg.min_brightness);
            REG_QUIET:  prdata = APB_DATA_W'(cfg_reg.quiet_age_ms);
            REG_SLOW:   prdata = APB_DATA_W'(cfg_reg.slow_interval_ms);
            REG_FAST:   prdata = APB_DATA_W'(cfg_reg.fast_interval_ms);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.park_gear_code   <= PARK_RST;
            cfg_reg.settle_time_ms   <= SETTLE_RST;
            cfg_reg.min_brightness   <= MINB_RST;
            cfg_reg.quiet_age_ms     <= QUIET_RST;
            cfg_reg.slow_interval_ms <= SLOW_RST;
            cfg_reg.fast_interval_ms <= FAST_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/dalc_door_step.sv
// Rule pass for one door: settling, door open and wait, display, blind-spot and turn rules.
// Depends on dalc_pkg for the door state type and the update struct.
module dalc_door_step
    import dalc_pkg::*;
(
    input  door_state_t         state,
    input  logic [NOW_W-1:0]    stamp,
    input  logic [NOW_W-1:0]    now_ms,
    input  logic [SETTLE_W-1:0] settle_time_ms,
    input  logic                is_open,
    input  logic                some_open,
    input  logic                display_on,
    input  logic                side_en,
    input  logic                blind,
    input  logic                turn,
    output door_upd_t           upd
);

    door_state_t      m;
    logic             full;
    logic             sub;
    logic [NOW_W-1:0] since;

    assign since = now_ms - stamp;

    // The rules run in a fixed order, each one seeing the mode left by the one before.
    always_comb
    begin
        m    = state;
        full = 1'b0;
        sub  = 1'b0;

        if (m == ST_SETTLING && since > NOW_W'(settle_time_ms))
        begin
            m = ST_IDLE; full = 1'b1;
        end

        if (is_open && m != ST_OPENED)
        begin
            m = ST_OPENED; full = 1'b1;
        end
        if (!is_open && m == ST_OPENED)
        begin
            m = ST_SETTLING; full = 1'b1;
        end

        if (some_open)
        begin
            if (!is_open && m != ST_DOOR_WAIT)
            begin
                m = ST_DOOR_WAIT; full = 1'b1;
            end
        end
        else if (m == ST_DOOR_WAIT)
        begin
            m = ST_SETTLING; full = 1'b1;
        end

        if (!display_on)
        begin
            if (m == ST_IDLE || m == ST_SETTLING)
            begin
                m = ST_WAIT; full = 1'b1;
            end
        end
        else if (m == ST_WAIT)
        begin
            m = ST_SETTLING; full = 1'b1;
        end

        // Blind-spot and turn rules apply to the two front doors only.
        // Moving between turning and turning with blind spot keeps the entry time.
        if (side_en)
        begin
            if (blind)
            begin
                if (m == ST_IDLE)
                begin
                    m = ST_BLIND; full = 1'b1;
                end
                if (m == ST_TURN)
                begin
                    m = ST_TURN_BLIND; sub = 1'b1;
                end
            end
            else
            begin
                if (m == ST_BLIND)
                begin
                    m = ST_IDLE; full = 1'b1;
                end
                if (m == ST_TURN_BLIND)
                begin
                    m = ST_TURN; sub = 1'b1;
                end
            end
            if (turn && m == ST_IDLE)
            begin
                m = ST_TURN; full = 1'b1;
            end
            if (turn && m == ST_BLIND)
            begin
                m = ST_TURN_BLIND; sub = 1'b1;
            end
            if (!turn && m == ST_TURN)
            begin
                m = ST_IDLE; full = 1'b1;
            end
            if (!turn && m == ST_TURN_BLIND)
            begin
                m = ST_BLIND; full = 1'b1;
            end
        end
    end

    always_comb
    begin
        upd.state   = m;
        upd.restamp = full;
        upd.changed = full | sub;
        upd.age     = full ? '0 : since;
    end

endmodule

FILE: sv/dalc_core.sv
// State and single-pass update of the controller: door modes, footwell, brightness, send timer.
// Depends on dalc_pkg and instantiates dalc_door_step for each door.
module dalc_core
    import dalc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  in_item_t   item,
    input  logic       fire,
    output out_item_t  result,
    output send_stat_t stat
);

    door_state_t         mode_reg   [DOORS];
    logic [NOW_W-1:0]    stamp_reg  [DOORS];
    logic [GEAR_W-1:0]   prev_gear_reg;
    logic                footwell_reg;
    logic [BRIGHT_W-1:0] bright_reg;
    logic                pending_reg;
    logic [NOW_W-1:0]    last_send_reg;

    logic                footwell_next;
    logic [BRIGHT_W-1:0] bright_next;
    logic                pending_next;

    door_upd_t           upd [DOORS];
    logic [DOORS-1:0]    blind_vec;
    logic [DOORS-1:0]    turn_vec;
    logic [DOORS-1:0]    changed_vec;
    logic [DOORS-1:0]    wait_vec;
    logic [DOORS-1:0]    idle_vec;
    logic                some_open;
    logic                pending_mid;
    logic [NOW_W-1:0]    min01;
    logic [NOW_W-1:0]    min23;
    logic [NOW_W-1:0]    min_age;
    logic [TIME_CFG_W-1:0] interval;
    logic                send;

    assign some_open = |item.doors_ajar;
    assign blind_vec = {2'b00, item.blind_left, item.blind_right};
    assign turn_vec  = {2'b00, item.turn_left, item.turn_right};

    for (genvar g = 0; g < DOORS; g++)
    begin : g_door
        dalc_door_step u_step (
            .state          (mode_reg[g]),
            .stamp          (stamp_reg[g]),
            .now_ms         (item.now_ms),
            .settle_time_ms (cfg.settle_time_ms),
            .is_open        (item.doors_ajar[g]),
            .some_open      (some_open),
            .display_on     (item.display_on),
            .side_en        (1'(g < SIDE_DOORS)),
            .blind          (blind_vec[g]),
            .turn           (turn_vec[g]),
            .upd            (upd[g])
        );
        assign changed_vec[g] = upd[g].changed;
        assign wait_vec[g]    = (upd[g].state == ST_WAIT);
        assign idle_vec[g]    = (upd[g].state == ST_IDLE);
    end

    // Footwell follows gear moves into and out of park and beyond.
    always_comb
    begin
        footwell_next = footwell_reg;
        if (prev_gear_reg != item.gear)
        begin
            if (prev_gear_reg <= cfg.park_gear_code && item.gear >= cfg.park_gear_code)
            begin
                footwell_next = 1'b0;
            end
            if (prev_gear_reg > cfg.park_gear_code && item.gear <= cfg.park_gear_code)
            begin
                footwell_next = 1'b1;
            end
        end
    end

    // A new requested brightness counts as a change before the floor is applied.
    always_comb
    begin
        bright_next = item.brightness_in;
        if ((some_open || item.gear < cfg.park_gear_code)
            && item.brightness_in < cfg.min_brightness)
        begin
            bright_next = cfg.min_brightness;
        end
    end

    assign pending_mid = pending_reg | (|changed_vec) | (bright_reg != item.brightness_in);

    assign min01   = (upd[1].age < upd[0].age) ? upd[1].age : upd[0].age;
    assign min23   = (upd[3].age < upd[2].age) ? upd[3].age : upd[2].age;
    assign min_age = (min23 < min01) ? min23 : min01;

    assign interval = (((&wait_vec) || (&idle_vec)) && min_age > NOW_W'(cfg.quiet_age_ms))
                      ? cfg.slow_interval_ms : cfg.fast_interval_ms;
    assign send = pending_mid || ((item.now_ms - last_send_reg) > NOW_W'(interval));
    assign pending_next = send ? 1'b0 : pending_mid;

    always_comb
    begin
        result.door0_mode      = mode_code(upd[0].state);
        result.door1_mode      = mode_code(upd[1].state);
        result.door2_mode      = mode_code(upd[2].state);
        result.door3_mode      = mode_code(upd[3].state);
        result.light_level     = bright_next;
        result.footwell_lit    = footwell_next;
        result.youngest_age_ms = min_age;
        result.send_now        = send;
    end

    assign stat.change_pending = pending_reg;
    assign stat.last_send_ms   = last_send_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DOORS; i++)
            begin
                mode_reg[i]  <= ST_SETTLING;
                stamp_reg[i] <= '0;
            end
            prev_gear_reg <= PARK_RST;
            footwell_reg  <= 1'b0;
            bright_reg    <= '0;
            pending_reg   <= 1'b1;
            last_send_reg <= '0;
        end
        else if (fire)
        begin
            for (int i = 0; i < DOORS; i++)
            begin
                mode_reg[i] <= upd[i].state;
                if (upd[i].restamp)
                begin
                    stamp_reg[i] <= item.now_ms;
                end
            end
            prev_gear_reg <= item.gear;
            footwell_reg  <= footwell_next;
            bright_reg    <= bright_next;
            pending_reg   <= pending_next;
            if (send)
            begin
                last_send_reg <= item.now_ms;
            end
        end
    end

endmodule
